// ===== hdl/mbrhp_pkg.sv =====
package mbrhp_pkg;

	// Limits of the record walk.
	localparam int MaxCombinables = 8;
	localparam int MaxDife = 10;

	// Result kinds.
	localparam logic [2:0] KIND_RECORD = 3'd0;
	localparam logic [2:0] KIND_COMB   = 3'd1;
	localparam logic [2:0] KIND_MFCT   = 3'd2;
	localparam logic [2:0] KIND_MORE   = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;

	// Value kinds.
	localparam logic [2:0] VK_NONE    = 3'd0;
	localparam logic [2:0] VK_INT     = 3'd1;
	localparam logic [2:0] VK_FLOAT   = 3'd2;
	localparam logic [2:0] VK_BCD     = 3'd3;
	localparam logic [2:0] VK_BCD_BAD = 3'd4;
	localparam logic [2:0] VK_VAR     = 3'd5;

	// Special DIF and VIF codes.
	localparam logic [7:0] DIF_MFCT   = 8'h0F;
	localparam logic [7:0] DIF_MORE   = 8'h1F;
	localparam logic [7:0] DIF_IDLE   = 8'h2F;
	localparam logic [7:0] VIF_EXT_FB = 8'hFB;
	localparam logic [7:0] VIF_EXT_FD = 8'hFD;
	localparam logic [7:0] VIF_EXT_EF = 8'hEF;
	localparam logic [7:0] VIF_EXT_FF = 8'hFF;
	localparam logic [6:0] VIF_ASCII  = 7'h7C;
	localparam logic [6:0] VIFE_EXT_A = 7'h7C;
	localparam logic [6:0] VIFE_EXT_B = 7'h7F;
	localparam logic [14:0] VIF_MASK  = 15'h7F7F;
	localparam logic [3:0] TYPE_FLOAT = 4'h5;
	localparam logic [3:0] TYPE_VAR   = 4'hD;

	localparam int NumRanges = 44;

	localparam logic [14:0] RangeLo [NumRanges] = '{
		15'h10, 15'h20, 15'h24, 15'h38, 15'h58, 15'h5C, 15'h60, 15'h64, 15'h68,
		15'h6E, 15'h6C, 15'h6D, 15'h08, 15'h00, 15'h28, 15'h30, 15'h74, 15'h78,
		15'h79, 15'h7B00, 15'h7B08, 15'h7B1A, 15'h7D08, 15'h7D09, 15'h7D0A,
		15'h7D0B, 15'h7D0C, 15'h7D0D, 15'h7D0E, 15'h7D0F, 15'h7D10, 15'h7D11,
		15'h7D17, 15'h7D1A, 15'h7D1B, 15'h7D2C, 15'h7D31, 15'h7D3A, 15'h7D40,
		15'h7D50, 15'h7D60, 15'h7D61, 15'h7D67, 15'h7D74};

	localparam logic [14:0] RangeHi [NumRanges] = '{
		15'h17, 15'h23, 15'h27, 15'h3F, 15'h5B, 15'h5F, 15'h63, 15'h67, 15'h6B,
		15'h6E, 15'h6C, 15'h6D, 15'h0F, 15'h07, 15'h2F, 15'h37, 15'h77, 15'h78,
		15'h79, 15'h7B01, 15'h7B09, 15'h7B1B, 15'h7D08, 15'h7D09, 15'h7D0A,
		15'h7D0B, 15'h7D0C, 15'h7D0D, 15'h7D0E, 15'h7D0F, 15'h7D10, 15'h7D11,
		15'h7D17, 15'h7D1A, 15'h7D1B, 15'h7D2F, 15'h7D33, 15'h7D3A, 15'h7D4F,
		15'h7D5F, 15'h7D60, 15'h7D61, 15'h7D67, 15'h7D74};

	// One result without the fields that the output stage adds.
	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         dif_byte;
		logic [40:0]        storage_number;
		logic [19:0]        tariff_number;
		logic [9:0]         subunit_number;
		logic [14:0]        vif_code;
		logic signed [63:0] value;
		logic [2:0]         value_kind;
		logic [15:0]        data_length;
		logic [15:0]        aux;
	} res_t;

	// Results caused by one byte, in order; cnt is the number in use.
	typedef struct packed {
		logic [1:0]       cnt;
		res_t [2:0]       res;
	} grp_t;

	function automatic logic [3:0] type_len(input logic [3:0] t);
		logic [3:0] len;
		case (t)
			4'h1, 4'h9: len = 4'd1;
			4'h2, 4'hA: len = 4'd2;
			4'h3, 4'hB: len = 4'd3;
			4'h4, 4'h5, 4'hC: len = 4'd4;
			4'h6, 4'hE: len = 4'd6;
			4'h7: len = 4'd8;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	// First matching entry of the range table, 1-based; 0 if none.
	function automatic logic [5:0] range_of(input logic [14:0] vif);
		logic [14:0] v;
		logic [5:0]  cls;
		v = vif & VIF_MASK;
		cls = '0;
		for (int i = NumRanges - 1; i >= 0; i--) begin
			if (v >= RangeLo[i] && v <= RangeHi[i]) begin
				cls = 6'(i + 1);
			end
		end
		return cls;
	endfunction

endpackage

// ===== hdl/mbrhp_if.sv =====
interface mbrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       end_of_payload;

	modport source (output valid, payload_byte, end_of_payload, input ready);
	modport sink (input valid, payload_byte, end_of_payload, output ready);
endinterface

interface mbrhp_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         dif_byte;
	logic [40:0]        storage_number;
	logic [19:0]        tariff_number;
	logic [9:0]         subunit_number;
	logic [14:0]        vif_code;
	logic [5:0]         range_class;
	logic signed [63:0] value;
	logic [2:0]         value_kind;
	logic [15:0]        data_length;
	logic [15:0]        aux;
	logic               last;

	modport source (output valid, kind, dif_byte, storage_number, tariff_number,
		subunit_number, vif_code, range_class, value, value_kind, data_length, aux,
		last, input ready);
	modport sink (input valid, kind, dif_byte, storage_number, tariff_number,
		subunit_number, vif_code, range_class, value, value_kind, data_length, aux,
		last, output ready);
endinterface

interface mbrhp_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/mbrhp_walker.sv =====
module mbrhp_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_eop,
	input  logic [9:0]         max_records,
	input  logic               grp_free,
	output logic               grp_load,
	output mbrhp_pkg::grp_t    grp
);

	localparam logic [3:0] PH_DIF     = 4'd0;
	localparam logic [3:0] PH_DIFE    = 4'd1;
	localparam logic [3:0] PH_VIF     = 4'd2;
	localparam logic [3:0] PH_VLEN    = 4'd3;
	localparam logic [3:0] PH_VSTR    = 4'd4;
	localparam logic [3:0] PH_VIFE    = 4'd5;
	localparam logic [3:0] PH_DATA    = 4'd6;
	localparam logic [3:0] PH_VARLEN  = 4'd7;
	localparam logic [3:0] PH_VARSKIP = 4'd8;
	localparam logic [3:0] PH_MFCT    = 4'd9;
	localparam logic [3:0] PH_STOP    = 4'd10;

	// Input register.
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;
	logic       adv;

	// Walk state.
	logic [3:0]  phase_q, nx_phase;
	logic [7:0]  dif_q, nx_dif;
	logic [3:0]  dife_q, nx_dife;
	logic [40:0] stor_q, nx_stor;
	logic [19:0] tar_q, nx_tar;
	logic [9:0]  sub_q, nx_sub;
	logic [14:0] vif_q, nx_vif;
	logic        extf_q, nx_extf;
	logic        cext_q, nx_cext;
	logic [6:0]  ceh_q, nx_ceh;
	logic [3:0]  ccnt_q, nx_ccnt;
	logic        vf_q, nx_vf;
	logic [7:0]  rem_q, nx_rem;
	logic [7:0]  vlen_q, nx_vlen;
	logic [3:0]  idx_q, nx_idx;
	logic [63:0] acc_q, nx_acc;
	logic [40:0] w_q, nx_w;
	logic        allf_q, nx_allf;
	logic [15:0] pos_q, nx_pos;
	logic [9:0]  rc_q, nx_rc;
	logic [15:0] moff_q, nx_moff;

	// Step logic.
	mbrhp_pkg::grp_t g;
	mbrhp_pkg::res_t r;
	logic [1:0]  n;
	logic        go_after, go_start, rec_go;
	logic [63:0] rec_val;
	logic [2:0]  rec_vk;
	logic [15:0] rec_len;
	logic [3:0]  t, tl;
	logic        bcd;
	logic [45:0] w1;
	logic [44:0] p_lo;
	logic [49:0] p_hi;
	logic [63:0] acc_b, acc_i, sx;
	logic [6:0]  c;
	logic [15:0] pos1;

	assign adv = vld_s1 && grp_free;
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eop_s1 <= in_eop;
		end
	end

	always_comb begin
		nx_phase = phase_q; nx_dif = dif_q; nx_dife = dife_q; nx_stor = stor_q;
		nx_tar = tar_q; nx_sub = sub_q; nx_vif = vif_q; nx_extf = extf_q;
		nx_cext = cext_q; nx_ceh = ceh_q; nx_ccnt = ccnt_q; nx_vf = vf_q;
		nx_rem = rem_q; nx_vlen = vlen_q; nx_idx = idx_q; nx_acc = acc_q;
		nx_w = w_q; nx_allf = allf_q; nx_rc = rc_q; nx_moff = moff_q;
		g = '0;
		r = '0;
		n = '0;
		go_after = 1'b0;
		go_start = 1'b0;
		rec_go = 1'b0;
		rec_val = '0;
		rec_vk = mbrhp_pkg::VK_NONE;
		rec_len = '0;
		pos1 = pos_q + 16'd1;
		nx_pos = pos1;
		c = byte_s1[6:0];

		// Data byte arithmetic: BCD digits weighted by powers of ten, or the
		// byte placed little-endian.
		t = dif_q[3:0];
		bcd = (t >= 4'h9 && t <= 4'hC) || t == 4'hE;
		w1 = ({5'd0, w_q} << 3) + ({5'd0, w_q} << 1);
		p_lo = byte_s1[3:0] * w_q;
		p_hi = byte_s1[7:4] * w1;
		acc_b = acc_q + 64'(p_lo);
		if (!(rem_q == 8'd1 && byte_s1[7:4] == 4'hF)) begin
			acc_b = acc_b + 64'(p_hi);
		end
		acc_i = acc_q | (64'(byte_s1) << {idx_q[2:0], 3'b000});
		case (idx_q + 4'd1)
			4'd1: sx = {{56{acc_i[7]}}, acc_i[7:0]};
			4'd2: sx = {{48{acc_i[15]}}, acc_i[15:0]};
			4'd3: sx = {{40{acc_i[23]}}, acc_i[23:0]};
			4'd4: sx = {{32{acc_i[31]}}, acc_i[31:0]};
			4'd5: sx = {{24{acc_i[39]}}, acc_i[39:0]};
			4'd6: sx = {{16{acc_i[47]}}, acc_i[47:0]};
			4'd7: sx = {{8{acc_i[55]}}, acc_i[55:0]};
			default: sx = acc_i;
		endcase

		case (phase_q)
			PH_DIF: begin
				if (rc_q >= max_records) begin
					r = '0; r.kind = mbrhp_pkg::KIND_DONE; r.aux = {6'd0, rc_q};
					g.res[n] = r; n = n + 2'd1;
					nx_phase = PH_STOP;
				end else if (byte_s1 == mbrhp_pkg::DIF_MFCT) begin
					nx_moff = pos1;
					nx_phase = PH_MFCT;
				end else if (byte_s1 == mbrhp_pkg::DIF_MORE) begin
					r = '0; r.kind = mbrhp_pkg::KIND_MORE;
					g.res[n] = r; n = n + 2'd1;
					r = '0; r.kind = mbrhp_pkg::KIND_DONE; r.aux = {6'd0, rc_q};
					g.res[n] = r; n = n + 2'd1;
					nx_phase = PH_STOP;
				end else if (byte_s1 == mbrhp_pkg::DIF_IDLE) begin
					nx_phase = PH_DIF;
				end else if (byte_s1[3:0] == 4'hF) begin
					r = '0; r.kind = mbrhp_pkg::KIND_DONE; r.aux = {6'd0, rc_q};
					g.res[n] = r; n = n + 2'd1;
					nx_phase = PH_STOP;
				end else begin
					nx_dif = byte_s1;
					nx_dife = '0;
					nx_stor = {40'd0, byte_s1[6]};
					nx_tar = '0; nx_sub = '0; nx_vif = '0;
					nx_extf = 1'b0; nx_cext = 1'b0; nx_ceh = '0; nx_ccnt = '0;
					nx_phase = byte_s1[7] ? PH_DIFE : PH_VIF;
				end
			end
			PH_DIFE: begin
				if (dife_q >= 4'(mbrhp_pkg::MaxDife)) begin
					r = '0; r.kind = mbrhp_pkg::KIND_DONE; r.aux = {6'd0, rc_q};
					g.res[n] = r; n = n + 2'd1;
					nx_phase = PH_STOP;
				end else begin
					nx_sub = sub_q | (10'(byte_s1[6]) << dife_q);
					nx_tar = tar_q | (20'(byte_s1[5:4]) << {dife_q, 1'b0});
					nx_stor = stor_q | (41'(byte_s1[3:0]) << ({2'b00, dife_q, 2'b00} + 8'd1));
					nx_dife = dife_q + 4'd1;
					if (!byte_s1[7]) begin
						nx_phase = PH_VIF;
					end
				end
			end
			PH_VIF: begin
				if (byte_s1 == mbrhp_pkg::VIF_EXT_FB || byte_s1 == mbrhp_pkg::VIF_EXT_FD ||
						byte_s1 == mbrhp_pkg::VIF_EXT_EF || byte_s1 == mbrhp_pkg::VIF_EXT_FF) begin
					nx_vif = {byte_s1[6:0], 8'd0};
					nx_extf = 1'b1;
				end else begin
					nx_vif = {8'd0, byte_s1[6:0]};
					nx_extf = 1'b0;
				end
				nx_cext = 1'b0;
				nx_vf = byte_s1[7];
				if (byte_s1[6:0] == mbrhp_pkg::VIF_ASCII) begin
					nx_phase = PH_VLEN;
				end else begin
					go_after = 1'b1;
				end
			end
			PH_VLEN: begin
				nx_rem = byte_s1;
				if (byte_s1 == 8'd0) begin
					go_after = 1'b1;
				end else begin
					nx_phase = PH_VSTR;
				end
			end
			PH_VSTR: begin
				nx_rem = rem_q - 8'd1;
				if (nx_rem == 8'd0) begin
					go_after = 1'b1;
				end
			end
			PH_VIFE: begin
				// Combinable codes carry the header as it stands.
				r = '0;
				r.kind = mbrhp_pkg::KIND_COMB;
				r.dif_byte = nx_dif; r.storage_number = nx_stor; r.tariff_number = nx_tar;
				r.subunit_number = nx_sub; r.vif_code = nx_vif;
				if (extf_q) begin
					nx_vif = vif_q | {8'd0, c};
					nx_extf = 1'b0;
				end else if (cext_q) begin
					if (ccnt_q < 4'(mbrhp_pkg::MaxCombinables)) begin
						r.aux = {1'b0, ceh_q, 1'b0, c};
						g.res[n] = r; n = n + 2'd1;
						nx_ccnt = ccnt_q + 4'd1;
					end
					nx_cext = 1'b0;
				end else if (c == mbrhp_pkg::VIFE_EXT_A || c == mbrhp_pkg::VIFE_EXT_B) begin
					nx_cext = 1'b1;
					nx_ceh = c;
				end else if (ccnt_q < 4'(mbrhp_pkg::MaxCombinables)) begin
					r.aux = {9'd0, c};
					g.res[n] = r; n = n + 2'd1;
					nx_ccnt = ccnt_q + 4'd1;
				end
				nx_vf = byte_s1[7];
				if (!byte_s1[7]) begin
					go_start = 1'b1;
				end
			end
			PH_DATA: begin
				nx_idx = idx_q + 4'd1;
				nx_rem = rem_q - 8'd1;
				if (bcd) begin
					nx_allf = allf_q && byte_s1 == 8'hFF;
					nx_acc = acc_b;
					nx_w = {w1[37:0], 3'b000} + {w1[39:0], 1'b0};
				end else begin
					nx_acc = acc_i;
				end
				if (nx_rem == 8'd0) begin
					rec_go = 1'b1;
					rec_len = {12'd0, nx_idx};
					if (bcd) begin
						if (nx_allf) begin
							rec_vk = mbrhp_pkg::VK_BCD_BAD;
						end else begin
							rec_vk = mbrhp_pkg::VK_BCD;
							rec_val = (byte_s1[7:4] == 4'hF) ? (64'd0 - acc_b) : acc_b;
						end
					end else if (t == mbrhp_pkg::TYPE_FLOAT) begin
						rec_vk = mbrhp_pkg::VK_FLOAT;
						rec_val = {32'd0, acc_i[31:0]};
						rec_len = 16'd4;
					end else begin
						rec_vk = mbrhp_pkg::VK_INT;
						rec_val = sx;
					end
				end
			end
			PH_VARLEN: begin
				nx_vlen = byte_s1;
				nx_rem = byte_s1;
				if (byte_s1 == 8'd0) begin
					rec_go = 1'b1;
					rec_vk = mbrhp_pkg::VK_VAR;
				end else begin
					nx_phase = PH_VARSKIP;
				end
			end
			PH_VARSKIP: begin
				nx_rem = rem_q - 8'd1;
				if (nx_rem == 8'd0) begin
					rec_go = 1'b1;
					rec_vk = mbrhp_pkg::VK_VAR;
					rec_len = {8'd0, vlen_q};
				end
			end
			default: begin
				nx_phase = phase_q;
			end
		endcase

		if (go_after) begin
			if (nx_vf) begin
				nx_phase = PH_VIFE;
			end else begin
				go_start = 1'b1;
			end
		end
		tl = mbrhp_pkg::type_len(nx_dif[3:0]);
		if (go_start) begin
			if (nx_dif[3:0] == mbrhp_pkg::TYPE_VAR) begin
				nx_phase = PH_VARLEN;
			end else if (tl == 4'd0) begin
				rec_go = 1'b1;
			end else begin
				nx_rem = {4'd0, tl};
				nx_idx = '0;
				nx_acc = '0;
				nx_w = 41'd1;
				nx_allf = 1'b1;
				nx_phase = PH_DATA;
			end
		end
		if (rec_go) begin
			r = '0;
			r.kind = mbrhp_pkg::KIND_RECORD;
			r.dif_byte = nx_dif; r.storage_number = nx_stor; r.tariff_number = nx_tar;
			r.subunit_number = nx_sub; r.vif_code = nx_vif;
			r.value = rec_val; r.value_kind = rec_vk; r.data_length = rec_len;
			g.res[n] = r; n = n + 2'd1;
			nx_rc = rc_q + 10'd1;
			nx_phase = PH_DIF;
		end

		// End of payload: report trailing manufacturer data, close the walk
		// and restart from the reset values.
		if (eop_s1) begin
			if (nx_phase == PH_MFCT) begin
				r = '0; r.kind = mbrhp_pkg::KIND_MFCT;
				r.aux = nx_moff; r.data_length = pos1 - nx_moff;
				g.res[n] = r; n = n + 2'd1;
			end
			if (nx_phase != PH_STOP) begin
				r = '0; r.kind = mbrhp_pkg::KIND_DONE; r.aux = {6'd0, nx_rc};
				g.res[n] = r; n = n + 2'd1;
			end
			nx_phase = PH_DIF; nx_dif = '0; nx_dife = '0; nx_stor = '0; nx_tar = '0;
			nx_sub = '0; nx_vif = '0; nx_extf = 1'b0; nx_cext = 1'b0; nx_ceh = '0;
			nx_ccnt = '0; nx_vf = 1'b0; nx_rem = '0; nx_vlen = '0; nx_idx = '0;
			nx_acc = '0; nx_w = 41'd1; nx_allf = 1'b1; nx_pos = '0; nx_rc = '0;
			nx_moff = '0;
		end
		g.cnt = n;
	end

	assign grp = g;
	assign grp_load = adv && g.cnt != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DIF; dif_q <= '0; dife_q <= '0; stor_q <= '0; tar_q <= '0;
			sub_q <= '0; vif_q <= '0; extf_q <= 1'b0; cext_q <= 1'b0; ceh_q <= '0;
			ccnt_q <= '0; vf_q <= 1'b0; rem_q <= '0; vlen_q <= '0; idx_q <= '0;
			acc_q <= '0; w_q <= 41'd1; allf_q <= 1'b1; pos_q <= '0; rc_q <= '0;
			moff_q <= '0;
		end else if (adv) begin
			phase_q <= nx_phase; dif_q <= nx_dif; dife_q <= nx_dife; stor_q <= nx_stor;
			tar_q <= nx_tar; sub_q <= nx_sub; vif_q <= nx_vif; extf_q <= nx_extf;
			cext_q <= nx_cext; ceh_q <= nx_ceh; ccnt_q <= nx_ccnt; vf_q <= nx_vf;
			rem_q <= nx_rem; vlen_q <= nx_vlen; idx_q <= nx_idx; acc_q <= nx_acc;
			w_q <= nx_w; allf_q <= nx_allf; pos_q <= nx_pos; rc_q <= nx_rc;
			moff_q <= nx_moff;
		end
	end

endmodule

// ===== hdl/mbrhp_emit.sv =====
module mbrhp_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               grp_load,
	input  mbrhp_pkg::grp_t    grp,
	output logic               grp_free,
	mbrhp_out_if.source        result
);

	logic            busy_q;
	logic [1:0]      idx_q;
	mbrhp_pkg::grp_t grp_s2;
	mbrhp_pkg::res_t cur;
	logic            fin;

	assign cur = grp_s2.res[idx_q];
	assign fin = result.valid && result.ready && idx_q == grp_s2.cnt - 2'd1;
	assign grp_free = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (grp_load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (fin) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (result.valid && result.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_s2 <= grp;
		end
	end

	assign result.valid = busy_q;
	assign result.kind = cur.kind;
	assign result.dif_byte = cur.dif_byte;
	assign result.storage_number = cur.storage_number;
	assign result.tariff_number = cur.tariff_number;
	assign result.subunit_number = cur.subunit_number;
	assign result.vif_code = cur.vif_code;
	assign result.value = cur.value;
	assign result.value_kind = cur.value_kind;
	assign result.data_length = cur.data_length;
	assign result.aux = cur.aux;
	assign result.last = idx_q == grp_s2.cnt - 2'd1;
	// Only records and combinable codes carry a range class.
	assign result.range_class =
		(cur.kind == mbrhp_pkg::KIND_RECORD || cur.kind == mbrhp_pkg::KIND_COMB) ?
		mbrhp_pkg::range_of(cur.vif_code) : 6'd0;

endmodule

// ===== hdl/mbus_record_header_parser.sv =====
// Channel   Dir  Carries
// payload   in   payload_byte, end_of_payload: one payload byte per item
// result    out  kind, header fields, range_class, value, value_kind,
//                data_length, aux, last: one result per item
// cfg       in   data: max_records, written whenever valid is high
//
// A byte is taken into an input register and walked from there; its results,
// up to three, land together in the output register stage. With one result
// or none per byte the block takes a byte every cycle while the result side
// does not stall; a byte with more results holds up the next until all are taken.
// Reset (arst_n low) returns the walk to waiting for a DIF and max_records
// to 1023. A stall on the result side fills the output stage and then the
// input register, after which ready on the payload side drops.
module mbus_record_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	mbrhp_in_if.sink     payload,
	mbrhp_out_if.source  result,
	mbrhp_cfg_if.sink    cfg
);

	logic [9:0]      max_records_q;
	logic            grp_free;
	logic            grp_load;
	mbrhp_pkg::grp_t grp;

	// The record limit register takes a write in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q <= 10'd1023;
		end else if (cfg.valid) begin
			max_records_q <= cfg.data;
		end
	end

	// The walker holds all record state and builds the results of one byte.
	mbrhp_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (payload.valid),
		.in_ready    (payload.ready),
		.in_byte     (payload.payload_byte),
		.in_eop      (payload.end_of_payload),
		.max_records (max_records_q),
		.grp_free    (grp_free),
		.grp_load    (grp_load),
		.grp         (grp)
	);

	// The emitter hands the results of one byte out one item at a time.
	mbrhp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_load (grp_load),
		.grp      (grp),
		.grp_free (grp_free),
		.result   (result)
	);

endmodule

// ===== hdl/mbrhp_checker.sv =====
module mbrhp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] kind,
	input logic [2:0] value_kind,
	input logic       last
);

	// A result waiting to be taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// Done always closes the results of its byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mbrhp_pkg::KIND_DONE |-> last)
		else $error("done result not marked last");

	// Marker and manufacturer results are always followed by done.
	a_more_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == mbrhp_pkg::KIND_MORE || kind == mbrhp_pkg::KIND_MFCT)
		|-> !last)
		else $error("marker or manufacturer result not followed by done");

	// Only records carry a value kind.
	a_vk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != mbrhp_pkg::KIND_RECORD |-> value_kind == mbrhp_pkg::VK_NONE)
		else $error("value kind on a result that is not a record");

endmodule

bind mbus_record_header_parser mbrhp_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.kind       (result.kind),
	.value_kind (result.value_kind),
	.last       (result.last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Top level of the testbench for the M-Bus record header parser.
module testbench;

	// Phases of the record walk as the predictor tracks them.
	localparam logic [3:0] WK_DIF     = 4'd0;
	localparam logic [3:0] WK_DIFE    = 4'd1;
	localparam logic [3:0] WK_VIF     = 4'd2;
	localparam logic [3:0] WK_VLEN    = 4'd3;
	localparam logic [3:0] WK_VSTR    = 4'd4;
	localparam logic [3:0] WK_VIFE    = 4'd5;
	localparam logic [3:0] WK_DATA    = 4'd6;
	localparam logic [3:0] WK_VARLEN  = 4'd7;
	localparam logic [3:0] WK_VARSKIP = 4'd8;
	localparam logic [3:0] WK_MFCT    = 4'd9;
	localparam logic [3:0] WK_STOP    = 4'd10;

	// One result item in the shape that the result channel carries it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  dif_byte;
		logic [40:0] storage_number;
		logic [19:0] tariff_number;
		logic [9:0]  subunit_number;
		logic [14:0] vif_code;
		logic [5:0]  range_class;
		logic [63:0] value;
		logic [2:0]  value_kind;
		logic [15:0] data_length;
		logic [15:0] aux;
		logic        last;
	} walk_result_t;

	localparam int CyclesLimit = 400000;
	localparam int LongHold = 300;
	localparam int DrainCycles = 8;
	localparam logic [40:0] Mask41 = {41{1'b1}};

	// Data bytes that each DIF type carries; variable and special types are zero.
	localparam logic [3:0] DataBytes [16] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd6, 4'd8,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd0};

	logic clk;
	logic arst_n;

	mbrhp_in_if  payload ();
	mbrhp_out_if result ();
	mbrhp_cfg_if cfg ();

	mbus_record_header_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(payload.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Shadow copy of the walk state and the one configuration register.
	logic [9:0]  max_records_q;
	logic [3:0]  phase_q;
	logic [7:0]  cur_dif;
	int          dife_n;
	int          comb_n;
	logic [6:0]  comb_high;
	logic [7:0]  remain;
	logic [7:0]  var_len;
	logic [3:0]  data_idx;
	bit          ext_first;
	bit          comb_pending;
	bit          all_f;
	bit          vife_more;
	logic [40:0] storage_acc;
	logic [19:0] tariff_acc;
	logic [9:0]  subunit_acc;
	logic [14:0] vif_acc;
	logic [63:0] value_acc;
	logic [63:0] bcd_weight;
	logic [15:0] byte_pos;
	logic [9:0]  record_n;
	logic [15:0] mfct_off;

	// Results of the byte being walked, and results still owed by the block.
	walk_result_t byte_results [$];
	walk_result_t expected_results [$];

	logic [7:0] payload_bytes [$];

	int fails;
	int cycle_n;
	int bytes_sent;
	bit idle_on;
	bit hold_req;

	function automatic logic [5:0] range_class_of(input logic [14:0] vif);
		logic [14:0] v;
		v = vif & mbrhp_pkg::VIF_MASK;
		for (int i = 0; i < mbrhp_pkg::NumRanges; i++) begin
			if (v >= mbrhp_pkg::RangeLo[i] && v <= mbrhp_pkg::RangeHi[i]) begin
				return 6'(i + 1);
			end
		end
		return 6'd0;
	endfunction

	function automatic walk_result_t header_result(input logic [2:0] k);
		walk_result_t r;
		r = '0;
		r.kind = k;
		r.dif_byte = cur_dif;
		r.storage_number = storage_acc;
		r.tariff_number = tariff_acc;
		r.subunit_number = subunit_acc;
		r.vif_code = vif_acc;
		r.range_class = range_class_of(vif_acc);
		return r;
	endfunction

	task automatic walk_clear();
		phase_q = WK_DIF;
		cur_dif = '0;
		dife_n = 0;
		comb_n = 0;
		comb_high = '0;
		remain = '0;
		var_len = '0;
		data_idx = '0;
		ext_first = 0;
		comb_pending = 0;
		vife_more = 0;
		all_f = 1;
		storage_acc = '0;
		tariff_acc = '0;
		subunit_acc = '0;
		vif_acc = '0;
		value_acc = '0;
		bcd_weight = 64'd1;
		byte_pos = '0;
		record_n = '0;
		mfct_off = '0;
	endtask

	task automatic stop_walk();
		walk_result_t r;
		r = '0;
		r.kind = mbrhp_pkg::KIND_DONE;
		r.aux = 16'(record_n);
		byte_results.push_back(r);
		phase_q = WK_STOP;
	endtask

	task automatic finish_record(input logic [63:0] v, input logic [2:0] vk,
		input logic [15:0] dlen);
		walk_result_t r;
		r = header_result(mbrhp_pkg::KIND_RECORD);
		r.value = v;
		r.value_kind = vk;
		r.data_length = dlen;
		byte_results.push_back(r);
		record_n = record_n + 10'd1;
		phase_q = WK_DIF;
	endtask

	task automatic begin_data();
		logic [3:0] t;
		t = cur_dif[3:0];
		if (t == mbrhp_pkg::TYPE_VAR) begin
			phase_q = WK_VARLEN;
		end else if (DataBytes[t] == 0) begin
			finish_record('0, mbrhp_pkg::VK_NONE, '0);
		end else begin
			remain = 8'(DataBytes[t]);
			data_idx = '0;
			value_acc = '0;
			bcd_weight = 64'd1;
			all_f = 1;
			phase_q = WK_DATA;
		end
	endtask

	task automatic after_vif();
		if (vife_more) begin
			phase_q = WK_VIFE;
		end else begin
			begin_data();
		end
	endtask

	task automatic walk_vife(input logic [7:0] b);
		walk_result_t r;
		logic [6:0] c;
		c = b[6:0];
		if (ext_first) begin
			vif_acc = vif_acc | 15'(c);
			ext_first = 0;
		end else if (comb_pending) begin
			if (comb_n < mbrhp_pkg::MaxCombinables) begin
				r = header_result(mbrhp_pkg::KIND_COMB);
				r.aux = {1'b0, comb_high, 1'b0, c};
				byte_results.push_back(r);
				comb_n++;
			end
			comb_pending = 0;
		end else if (c == mbrhp_pkg::VIFE_EXT_A || c == mbrhp_pkg::VIFE_EXT_B) begin
			comb_pending = 1;
			comb_high = c;
		end else if (comb_n < mbrhp_pkg::MaxCombinables) begin
			r = header_result(mbrhp_pkg::KIND_COMB);
			r.aux = 16'(c);
			byte_results.push_back(r);
			comb_n++;
		end
		vife_more = b[7];
		if (!vife_more) begin
			begin_data();
		end
	endtask

	task automatic walk_data(input logic [7:0] b);
		logic [3:0]  t;
		bit          bcd;
		bit          last_byte;
		int          bits;
		logic [63:0] v;
		t = cur_dif[3:0];
		bcd = (t >= 4'h9 && t <= 4'hC) || t == 4'hE;
		last_byte = remain == 8'd1;
		if (bcd) begin
			if (b != 8'hFF) begin
				all_f = 0;
			end
			value_acc = value_acc + 64'(b[3:0]) * bcd_weight;
			bcd_weight = bcd_weight * 64'd10;
			if (!(last_byte && b[7:4] == 4'hF)) begin
				value_acc = value_acc + 64'(b[7:4]) * bcd_weight;
			end
			bcd_weight = (bcd_weight * 64'd10) & 64'(Mask41);
		end else begin
			value_acc = value_acc | (64'(b) << (8 * data_idx[2:0]));
		end
		data_idx = data_idx + 4'd1;
		remain = remain - 8'd1;
		if (remain != 0) begin
			return;
		end
		if (bcd) begin
			if (all_f) begin
				finish_record('0, mbrhp_pkg::VK_BCD_BAD, 16'(data_idx));
			end else begin
				v = (b[7:4] == 4'hF) ? -value_acc : value_acc;
				finish_record(v, mbrhp_pkg::VK_BCD, 16'(data_idx));
			end
		end else if (t == mbrhp_pkg::TYPE_FLOAT) begin
			finish_record({32'd0, value_acc[31:0]}, mbrhp_pkg::VK_FLOAT, 16'd4);
		end else begin
			bits = 8 * data_idx;
			v = value_acc;
			if (bits > 0 && bits < 64 && v[bits - 1]) begin
				v = v | ({64{1'b1}} << bits);
			end
			finish_record(v, mbrhp_pkg::VK_INT, 16'(data_idx));
		end
	endtask

	task automatic walk_dif(input logic [7:0] b, input logic [15:0] pos);
		walk_result_t r;
		if (record_n >= max_records_q) begin
			stop_walk();
		end else if (b == mbrhp_pkg::DIF_MFCT) begin
			mfct_off = pos + 16'd1;
			phase_q = WK_MFCT;
		end else if (b == mbrhp_pkg::DIF_MORE) begin
			r = '0;
			r.kind = mbrhp_pkg::KIND_MORE;
			byte_results.push_back(r);
			stop_walk();
		end else if (b == mbrhp_pkg::DIF_IDLE) begin
			// Padding between records is skipped.
		end else if (b[3:0] == 4'hF) begin
			stop_walk();
		end else begin
			cur_dif = b;
			dife_n = 0;
			storage_acc = 41'(b[6]);
			tariff_acc = '0;
			subunit_acc = '0;
			vif_acc = '0;
			ext_first = 0;
			comb_pending = 0;
			comb_high = '0;
			comb_n = 0;
			phase_q = b[7] ? WK_DIFE : WK_VIF;
		end
	endtask

	// Walks one accepted byte and queues every result that it causes.
	task automatic walk_byte(input logic [7:0] b, input logic eop);
		logic [15:0]  pos;
		walk_result_t r;
		bit           ext;
		pos = byte_pos;
		byte_results.delete();
		case (phase_q)
			WK_DIF: walk_dif(b, pos);
			WK_DIFE: begin
				if (dife_n >= mbrhp_pkg::MaxDife) begin
					stop_walk();
				end else begin
					subunit_acc = subunit_acc | (10'(b[6]) << dife_n);
					tariff_acc = tariff_acc | (20'(b[5:4]) << (2 * dife_n));
					storage_acc = storage_acc | (41'(b[3:0]) << (1 + 4 * dife_n));
					dife_n++;
					if (!b[7]) begin
						phase_q = WK_VIF;
					end
				end
			end
			WK_VIF: begin
				ext = b == mbrhp_pkg::VIF_EXT_FB || b == mbrhp_pkg::VIF_EXT_FD ||
					b == mbrhp_pkg::VIF_EXT_EF || b == mbrhp_pkg::VIF_EXT_FF;
				vif_acc = ext ? {b[6:0], 8'h00} : 15'(b[6:0]);
				ext_first = ext;
				comb_pending = 0;
				vife_more = b[7];
				if (b[6:0] == mbrhp_pkg::VIF_ASCII) begin
					phase_q = WK_VLEN;
				end else begin
					after_vif();
				end
			end
			WK_VLEN: begin
				remain = b;
				if (b == 0) begin
					after_vif();
				end else begin
					phase_q = WK_VSTR;
				end
			end
			WK_VSTR: begin
				remain = remain - 8'd1;
				if (remain == 0) begin
					after_vif();
				end
			end
			WK_VIFE: walk_vife(b);
			WK_DATA: walk_data(b);
			WK_VARLEN: begin
				var_len = b;
				remain = b;
				if (b == 0) begin
					finish_record('0, mbrhp_pkg::VK_VAR, '0);
				end else begin
					phase_q = WK_VARSKIP;
				end
			end
			WK_VARSKIP: begin
				remain = remain - 8'd1;
				if (remain == 0) begin
					finish_record('0, mbrhp_pkg::VK_VAR, 16'(var_len));
				end
			end
			default: begin
			end
		endcase
		byte_pos = pos + 16'd1;
		if (eop) begin
			if (phase_q == WK_MFCT) begin
				r = '0;
				r.kind = mbrhp_pkg::KIND_MFCT;
				r.aux = mfct_off;
				r.data_length = pos + 16'd1 - mfct_off;
				byte_results.push_back(r);
				stop_walk();
			end else if (phase_q != WK_STOP) begin
				stop_walk();
			end
			walk_clear();
		end
		if (byte_results.size() > 0) begin
			byte_results[byte_results.size() - 1].last = 1'b1;
		end
		foreach (byte_results[i]) begin
			expected_results.push_back(byte_results[i]);
		end
	endtask

	// Offers one byte, waits for the handshake and then predicts its results.
	// Valid stays high between back-to-back bytes, so it is never lowered and
	// raised again in one time step.
	task automatic send_byte(input logic [7:0] b, input logic eop);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			payload.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		payload.valid <= 1'b1;
		payload.payload_byte <= b;
		payload.end_of_payload <= eop;
		do @(posedge clk); while (!payload.ready);
		walk_byte(b, eop);
		bytes_sent++;
	endtask

	task automatic send_payload();
		foreach (payload_bytes[i]) begin
			send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
		end
	endtask

	// Waits until the block owes nothing, then lets trailing work settle.
	task automatic wait_drained();
		payload.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_max_records(input logic [9:0] v);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		max_records_q = v;
	endtask

	// Appends one well-formed record with random content to the payload.
	task automatic add_record();
		logic [3:0] t;
		int         n_dife;
		int         n_vife;
		int         vif_mode;
		int         data_mode;
		int         len;
		logic [7:0] b;
		t = 4'($urandom_range(0, 14));
		n_dife = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 2);
		vif_mode = $urandom_range(0, 5);
		n_vife = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 3);
		if (vif_mode == 1 && n_vife == 0) begin
			n_vife = 1;
		end
		b = {n_dife > 0, 1'($urandom), 2'($urandom), t};
		payload_bytes.push_back(b);
		for (int i = 0; i < n_dife; i++) begin
			payload_bytes.push_back({i < n_dife - 1, 7'($urandom)});
		end
		case (vif_mode)
			1: begin
				case ($urandom_range(0, 3))
					0: b = mbrhp_pkg::VIF_EXT_FB;
					1: b = mbrhp_pkg::VIF_EXT_FD;
					2: b = mbrhp_pkg::VIF_EXT_EF;
					default: b = mbrhp_pkg::VIF_EXT_FF;
				endcase
				payload_bytes.push_back(b);
			end
			2: begin
				payload_bytes.push_back({n_vife > 0, mbrhp_pkg::VIF_ASCII});
				len = $urandom_range(0, 3);
				payload_bytes.push_back(8'(len));
				for (int i = 0; i < len; i++) begin
					payload_bytes.push_back(8'($urandom));
				end
			end
			default: begin
				b = {n_vife > 0, 7'($urandom)};
				if (b[6:0] == mbrhp_pkg::VIF_ASCII) begin
					b[0] = 1'b1;
				end
				payload_bytes.push_back(b);
			end
		endcase
		for (int i = 0; i < n_vife; i++) begin
			b[6:0] = ($urandom_range(0, 4) == 0) ?
				($urandom_range(0, 1) ? mbrhp_pkg::VIFE_EXT_A : mbrhp_pkg::VIFE_EXT_B) :
				7'($urandom);
			b[7] = i < n_vife - 1;
			payload_bytes.push_back(b);
		end
		if (t == mbrhp_pkg::TYPE_VAR) begin
			len = $urandom_range(0, 4);
			payload_bytes.push_back(8'(len));
		end else begin
			len = DataBytes[t];
		end
		data_mode = $urandom_range(0, 3);
		for (int i = 0; i < len; i++) begin
			case (data_mode)
				0: b = 8'hFF;
				1: b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				2: b = (i == len - 1) ? {4'hF, 4'($urandom_range(0, 9))} :
					{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				default: b = 8'($urandom);
			endcase
			payload_bytes.push_back(b);
		end
	endtask

	// Builds one payload: mostly records with a random ending, some noise,
	// and now and then one cut short inside a record.
	task automatic build_payload();
		int n;
		payload_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				payload_bytes.push_back(8'($urandom));
			end
			return;
		end
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				payload_bytes.push_back(mbrhp_pkg::DIF_IDLE);
			end
			add_record();
		end
		case ($urandom_range(0, 5))
			0: begin
				payload_bytes.push_back(mbrhp_pkg::DIF_MFCT);
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					payload_bytes.push_back(8'($urandom));
				end
			end
			1: begin
				payload_bytes.push_back(mbrhp_pkg::DIF_MORE);
				payload_bytes.push_back(8'($urandom));
			end
			2: payload_bytes.push_back({4'($urandom_range(2, 15)), 4'hF});
			default: begin
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, payload_bytes.size());
			while (payload_bytes.size() > n) payload_bytes.pop_back();
		end
	endtask

	task automatic test_directed_records();
		// Padding, a negative 32-bit integer, an all-F BCD field, a negative
		// BCD value, float bits behind an extension VIF, a 16-bit combinable
		// code with an 8-bit integer, variable data, then manufacturer data.
		payload_bytes = '{mbrhp_pkg::DIF_IDLE, 8'h04, 8'h13, 8'h00, 8'h00, 8'h00, 8'h80,
			8'h0C, 8'h13, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h0A, 8'h93, 8'h05, 8'h34, 8'hF2,
			8'h05, mbrhp_pkg::VIF_EXT_FD, 8'h17, 8'h00, 8'h00, 8'h80, 8'h3F,
			8'h01, 8'h93, 8'hFF, 8'h05, 8'hFF,
			8'h0D, 8'h13, 8'h02, 8'hAA, 8'hBB,
			mbrhp_pkg::DIF_MFCT, 8'h11, 8'h22};
		send_payload();
		// More-records marker followed by a byte that is ignored.
		payload_bytes = '{mbrhp_pkg::DIF_MORE, 8'h00};
		send_payload();
		// A record cut short, ending on an all-ones byte.
		payload_bytes = '{8'hC4, 8'hFF};
		send_payload();
	endtask

	task automatic test_record_limit();
		write_max_records(10'd0);
		payload_bytes = '{8'h01, 8'h13, 8'h7F};
		send_payload();
		write_max_records(10'd1);
		payload_bytes = '{8'h01, 8'h13, 8'h7F, 8'h01, 8'h13, 8'h01};
		send_payload();
		write_max_records(10'd1023);
	endtask

	// The result side holds off for a long stretch while bytes keep coming,
	// then the sender waits for every owed result before going on.
	task automatic test_backpressure();
		hold_req = 1;
		repeat (3) begin
			build_payload();
			send_payload();
		end
		wait_drained();
		build_payload();
		send_payload();
	endtask

	task automatic test_random_walk();
		int phase_n;
		phase_n = 0;
		while (bytes_sent < 170) begin
			if (bytes_sent > 130) begin
				idle_on = 0;
			end
			build_payload();
			send_payload();
			phase_n++;
			if (phase_n % 12 == 0) begin
				write_max_records($urandom_range(0, 1) ? 10'($urandom_range(1, 4)) :
					10'($urandom));
			end
		end
		idle_on = 0;
		write_max_records(10'd1023);
		repeat (4) begin
			build_payload();
			send_payload();
		end
	endtask

	// Result side: random stall bursts, plus one long hold on request.
	int hold_left;
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = LongHold;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			hold_left = $urandom_range(1, 3);
		end
		result.ready <= (hold_left == 0);
	end

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	// Every accepted result is matched against the oldest owed one.
	always @(posedge clk) begin
		walk_result_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				$error("kind: expected no result, got %0h", result.kind);
				fails++;
			end else begin
				e = expected_results.pop_front();
				check_field("kind", e.kind, result.kind);
				check_field("dif_byte", e.dif_byte, result.dif_byte);
				check_field("storage_number", e.storage_number, result.storage_number);
				check_field("tariff_number", e.tariff_number, result.tariff_number);
				check_field("subunit_number", e.subunit_number, result.subunit_number);
				check_field("vif_code", e.vif_code, result.vif_code);
				check_field("range_class", e.range_class, result.range_class);
				check_field("value", e.value, result.value);
				check_field("value_kind", e.value_kind, result.value_kind);
				check_field("data_length", e.data_length, result.data_length);
				check_field("aux", e.aux, result.aux);
				check_field("last", e.last, result.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CyclesLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		fails = 0;
		cycle_n = 0;
		bytes_sent = 0;
		hold_req = 0;
		hold_left = 0;
		idle_on = 1;
		max_records_q = 10'd1023;
		walk_clear();
		arst_n = 1'b0;
		payload.valid = 1'b0;
		payload.payload_byte = '0;
		payload.end_of_payload = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		result.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_records();
		test_record_limit();
		test_backpressure();
		test_random_walk();

		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mbrhp_pkg.sv
hdl/mbrhp_if.sv
hdl/mbrhp_walker.sv
hdl/mbrhp_emit.sv
hdl/mbus_record_header_parser.sv
hdl/mbrhp_checker.sv
tb/testbench.sv
